@@ hdl/chi_pkg.sv @@
// chi_pkg: shared constants and pipeline record types for the cubic hermite interpolator
// no dependencies
package chi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32 + FRAC_BITS;
  localparam int MUL_LAT   = 4;
  localparam int NGRP      = 4;

  localparam logic [59:0] PROD_LIM = {60{1'b1}};
  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic               zero;
    logic               neg;
    logic signed [32:0] d;
    logic signed [31:0] v0;
    logic signed [31:0] v1;
    logic signed [31:0] s0;
    logic signed [31:0] s1;
  } side_t;

  typedef struct packed {
    logic          valid;
    logic [31:0]   rem;
    logic [DW-1:0] qd;
    logic [31:0]   dv;
    side_t         side;
  } cell_t;

  typedef struct packed {
    logic               valid;
    logic               zero;
    logic               ovf;
    logic signed [32:0] d;
    logic signed [31:0] v0;
    logic signed [31:0] v1;
    logic signed [31:0] s0;
    logic signed [31:0] s1;
    logic signed [63:0] t;
    logic signed [63:0] t2;
    logic signed [63:0] t3;
    logic signed [63:0] h00;
    logic signed [63:0] h01;
    logic signed [63:0] g10;
    logic signed [63:0] g11;
    logic signed [63:0] h10;
    logic signed [63:0] h11;
    logic signed [63:0] sum;
  } ctx_t;

endpackage

@@ hdl/chi_div_cell.sv @@
// chi_div_cell: one restoring division step, one quotient bit per cell
// depends on chi_pkg
module chi_div_cell import chi_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cell_t din,
  output cell_t dout
);

  logic [32:0] r2;
  logic [32:0] diff;
  logic        ge;
  cell_t       dout_next;

  always_comb begin
    r2             = {din.rem, din.qd[DW-1]};
    diff           = r2 - {1'b0, din.dv};
    ge             = r2 >= {1'b0, din.dv};
    dout_next      = din;
    dout_next.rem  = ge ? diff[31:0] : r2[31:0];
    dout_next.qd   = {din.qd[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule

@@ hdl/chi_mulq.sv @@
// chi_mulq: pipelined signed fixed point product, truncated and saturated
// depends on chi_pkg
module chi_mulq import chi_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] p,
  output logic               ovf
);

  logic [63:0]  ua, ub;
  logic         neg1, neg2, neg3;
  logic [63:0]  p00, p01, p10, p11;
  logic [127:0] prod;
  logic [59:0]  mag;
  logic         big;
  logic [63:0]  m64;

  always_comb begin
    prod = {64'b0, p00} + {32'b0, p01, 32'b0} + {32'b0, p10, 32'b0} + {p11, 64'b0};
    m64  = {4'b0, big ? PROD_LIM : mag};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ua   <= a[63] ? 64'(-a) : 64'(a);
      ub   <= b[63] ? 64'(-b) : 64'(b);
      neg1 <= a[63] ^ b[63];
      p00  <= ua[31:0] * ub[31:0];
      p01  <= ua[31:0] * ub[63:32];
      p10  <= ua[63:32] * ub[31:0];
      p11  <= ua[63:32] * ub[63:32];
      neg2 <= neg1;
      mag  <= prod[FRAC_BITS+59:FRAC_BITS];
      big  <= |prod[127:FRAC_BITS+60];
      neg3 <= neg2;
      p    <= neg3 ? -$signed(m64) : $signed(m64);
      ovf  <= big;
    end
  end

endmodule

@@ hdl/cubic_hermite_interpolator_top.sv @@
// cubic_hermite_interpolator_top: one beat in, one beat out, fully pipelined
// pipeline: input register, one divider cell per quotient bit (32 + FRAC_BITS), t register,
// four product groups (a multiplier with a matching delay line, then a register each),
// basis register, output register
// throughput: one beat per cycle; the whole pipeline holds while a result waits
// reset: synchronous, clears all valid state; no clearing pass
module cubic_hermite_interpolator_top import chi_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // query_pos, knot_start, knot_end, value_start, value_end, slope_start, slope_end
  input  logic [223:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // interp_value
  output logic [31:0]  m_tdata,
  // overflow, zero_span
  output logic [1:0]   m_tuser
);

  logic               en;
  logic signed [31:0] q, k0, k1;
  logic signed [32:0] num, d;
  cell_t              c [DW+1];
  cell_t              c0_next;
  ctx_t               ct, r1, r2, hr, r3, r4;
  ctx_t               ct_next, r1_next, r2_next, hr_next, r3_next, r4_next;
  ctx_t               src [NGRP];
  ctx_t               dl  [NGRP][MUL_LAT];
  logic signed [63:0] pa, pb, pc, pd, pe, pf, pg, ph;
  logic               oa, ob, oc, od, oe, of_, og, oh;
  logic [DW-1:0]      qm;
  logic signed [63:0] tq;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign q   = s_tdata[31:0];
  assign k0  = s_tdata[63:32];
  assign k1  = s_tdata[95:64];
  assign num = {q[31], q} - {k0[31], k0};
  assign d   = {k1[31], k1} - {k0[31], k0};

  always_comb begin
    c0_next           = '0;
    c0_next.valid     = s_tvalid;
    c0_next.qd        = {num[32] ? 32'(-num) : num[31:0], {FRAC_BITS{1'b0}}};
    c0_next.dv        = d[32] ? 32'(-d) : d[31:0];
    c0_next.side.zero = d == '0;
    c0_next.side.neg  = num[32] ^ d[32];
    c0_next.side.d    = d;
    c0_next.side.v0   = s_tdata[127:96];
    c0_next.side.v1   = s_tdata[159:128];
    c0_next.side.s0   = s_tdata[191:160];
    c0_next.side.s1   = s_tdata[223:192];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c[0] <= '0;
    end else if (en) begin
      c[0] <= c0_next;
    end
  end

  for (genvar i = 0; i < DW; i++) begin : g_div
    chi_div_cell u_cell (.clk(clk), .rst(rst), .en(en), .din(c[i]), .dout(c[i+1]));
  end

  assign qm = c[DW].qd;
  assign tq = c[DW].side.neg ? -$signed({{(64-DW){1'b0}}, qm}) : $signed({{(64-DW){1'b0}}, qm});

  always_comb begin
    ct_next       = '0;
    ct_next.valid = c[DW].valid;
    ct_next.zero  = c[DW].side.zero;
    ct_next.d     = c[DW].side.d;
    ct_next.v0    = c[DW].side.v0;
    ct_next.v1    = c[DW].side.v1;
    ct_next.s0    = c[DW].side.s0;
    ct_next.s1    = c[DW].side.s1;
    ct_next.t     = tq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ct <= '0;
    end else if (en) begin
      ct <= ct_next;
    end
  end

  assign src[0] = ct;
  assign src[1] = r1;
  assign src[2] = hr;
  assign src[3] = r3;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < NGRP; g++) begin
        for (int k = 0; k < MUL_LAT; k++) begin
          dl[g][k] <= '0;
        end
      end
    end else if (en) begin
      for (int g = 0; g < NGRP; g++) begin
        dl[g][0] <= src[g];
        for (int k = 1; k < MUL_LAT; k++) begin
          dl[g][k] <= dl[g][k-1];
        end
      end
    end
  end

  chi_mulq u_ma (.clk(clk), .en(en), .a(ct.t),  .b(ct.t), .p(pa), .ovf(oa));
  chi_mulq u_mb (.clk(clk), .en(en), .a(r1.t2), .b(r1.t), .p(pb), .ovf(ob));
  chi_mulq u_mc (.clk(clk), .en(en), .a(hr.g10), .b(64'(hr.d)), .p(pc), .ovf(oc));
  chi_mulq u_md (.clk(clk), .en(en), .a(hr.g11), .b(64'(hr.d)), .p(pd), .ovf(od));
  chi_mulq u_me (.clk(clk), .en(en), .a(r3.h00), .b(64'(r3.v0)), .p(pe), .ovf(oe));
  chi_mulq u_mf (.clk(clk), .en(en), .a(r3.h10), .b(64'(r3.s0)), .p(pf), .ovf(of_));
  chi_mulq u_mg (.clk(clk), .en(en), .a(r3.h01), .b(64'(r3.v1)), .p(pg), .ovf(og));
  chi_mulq u_mh (.clk(clk), .en(en), .a(r3.h11), .b(64'(r3.s1)), .p(ph), .ovf(oh));

  always_comb begin
    r1_next     = dl[0][MUL_LAT-1];
    r1_next.t2  = pa;
    r1_next.ovf = dl[0][MUL_LAT-1].ovf | oa;
    r2_next     = dl[1][MUL_LAT-1];
    r2_next.t3  = pb;
    r2_next.ovf = dl[1][MUL_LAT-1].ovf | ob;
    hr_next     = r2;
    hr_next.h00 = 2 * r2.t3 - 3 * r2.t2 + ONE;
    hr_next.h01 = 3 * r2.t2 - 2 * r2.t3;
    hr_next.g10 = r2.t3 - 2 * r2.t2 + r2.t;
    hr_next.g11 = r2.t3 - r2.t2;
    r3_next     = dl[2][MUL_LAT-1];
    r3_next.h10 = pc;
    r3_next.h11 = pd;
    r3_next.ovf = dl[2][MUL_LAT-1].ovf | oc | od;
    r4_next     = dl[3][MUL_LAT-1];
    r4_next.sum = pe + pf + pg + ph;
    r4_next.ovf = dl[3][MUL_LAT-1].ovf | oe | of_ | og | oh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1 <= '0;
      r2 <= '0;
      hr <= '0;
      r3 <= '0;
      r4 <= '0;
    end else if (en) begin
      r1 <= r1_next;
      r2 <= r2_next;
      hr <= hr_next;
      r3 <= r3_next;
      r4 <= r4_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= r4.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (r4.zero) begin
        m_tdata <= r4.v0;
        m_tuser <= 2'b10;
      end else if (r4.sum > SAT_MAX) begin
        m_tdata <= SAT_MAX[31:0];
        m_tuser <= 2'b01;
      end else if (r4.sum < SAT_MIN) begin
        m_tdata <= SAT_MIN[31:0];
        m_tuser <= 2'b01;
      end else begin
        m_tdata <= r4.sum[31:0];
        m_tuser <= {1'b0, r4.ovf};
      end
    end
  end

`ifndef SYNTH
  a_zero_no_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0])
    else $error("zero span beat flagged overflow");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(ct) && $stable(r4))
    else $error("pipeline moved during stall");
`endif

endmodule
